// ===== hw/rtl/chs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the chained hash set.
// No dependencies; the interfaces, front, back, top level and testbench use it.
package chs_pkg;

    localparam int KEY_W     = 31;
    localparam int CMD_W     = 2;
    localparam int SEL_W     = 4;
    localparam int STATUS_W  = 3;

    // key mod BUCKETS is found four key bits per cycle, MSB first
    localparam int HASH_BITS  = 4;
    localparam int HASH_STEPS = (KEY_W + HASH_BITS - 1) / HASH_BITS;
    localparam int PAD_W      = HASH_BITS * HASH_STEPS;
    localparam int STEP_W     = $clog2(HASH_STEPS);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_FULL      = 3'd4,
        ST_ENTRY     = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

endpackage

// ===== hw/rtl/chs_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on chs_pkg for field widths.
interface chs_in_if;
    logic                         valid;
    logic                         ready;
    logic [chs_pkg::CMD_W-1:0]    command;
    logic [chs_pkg::KEY_W-1:0]    key;
    logic [chs_pkg::SEL_W-1:0]    bucket;

    modport source (output valid, command, key, bucket, input ready);
    modport sink   (input valid, command, key, bucket, output ready);
endinterface

interface chs_out_if;
    logic                         valid;
    logic                         ready;
    logic [chs_pkg::STATUS_W-1:0] status;
    logic [chs_pkg::KEY_W-1:0]    value;
    logic                         last;

    modport source (output valid, status, value, last, input ready);
    modport sink   (input valid, status, value, last, output ready);
endinterface

// ===== hw/rtl/chs_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/chs_fifo.sv =====
`timescale 1ns / 1ps
// Small FIFO that decouples the classify front from the execute back.
// No dependencies.
module chs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/chs_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, hashes keys (key mod BUCKETS, 4 bits a cycle)
// and queues decoded operations. Depends on chs_pkg and chs_in_if.
module chs_front #(
    parameter int BUCKETS     = 11,
    parameter int CHAIN_DEPTH = 8
) (
    input  logic    clk,
    input  logic    rst_n,
    chs_in_if.sink  request,
    input  logic    clearing,
    output logic    push,
    output logic [chs_pkg::CMD_W + chs_pkg::KEY_W + $clog2(BUCKETS)
                  + $clog2(BUCKETS * CHAIN_DEPTH) : 0] push_data,
    input  logic    full
);

    import chs_pkg::*;

    localparam int BW  = $clog2(BUCKETS);
    localparam int KAW = $clog2(BUCKETS * CHAIN_DEPTH);

    typedef struct packed {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [BW-1:0]    bidx;
        logic [KAW-1:0]   base;
        logic             rd_ok;
    } op_t;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t           state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [BW-1:0]     rem_reg, rem_next;
    logic [PAD_W-1:0]  sh_reg, sh_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [BW-1:0]     rem_step;
    logic [BW:0]       trial;
    logic              sel_ok;
    op_t               op;

    assign request.ready = (state_reg == F_IDLE) && !clearing;
    assign sel_ok = (32'(request.bucket) < 32'(BUCKETS));

    // four restoring remainder steps per cycle
    always_comb
    begin
        rem_step = rem_reg;
        trial    = '0;
        for (int j = 0; j < HASH_BITS; j++)
        begin
            trial = {rem_step, sh_reg[PAD_W-1-j]};
            if (trial >= (BW+1)'(BUCKETS))
            begin
                trial = trial - (BW+1)'(BUCKETS);
            end
            rem_step = trial[BW-1:0];
        end
    end

    // operation handed to the back end
    always_comb
    begin
        op.cmd   = cmd_reg;
        op.key   = key_reg;
        op.bidx  = rem_reg;
        op.base  = KAW'(rem_reg) * KAW'(CHAIN_DEPTH);
        op.rd_ok = rd_ok_reg;
    end

    assign push      = (state_reg == F_PUSH);
    assign push_data = op;

    // control
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        step_next  = step_reg;
        rd_ok_next = rd_ok_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (request.valid && request.ready)
                begin
                    key_next = request.key;
                    case (request.command)
                        CMD_INSERT, CMD_REMOVE:
                        begin
                            cmd_next   = cmd_t'(request.command);
                            rem_next   = '0;
                            sh_next    = PAD_W'(request.key);
                            step_next  = '0;
                            rd_ok_next = 1'b1;
                            state_next = F_HASH;
                        end
                        CMD_READ:
                        begin
                            cmd_next   = CMD_READ;
                            rem_next   = sel_ok ? BW'(request.bucket) : '0;
                            rd_ok_next = sel_ok;
                            state_next = F_PUSH;
                        end
                        default:
                        begin
                            // undefined command: dropped
                            state_next = F_IDLE;
                        end
                    endcase
                end
            end
            F_HASH:
            begin
                rem_next  = rem_step;
                sh_next   = sh_reg << HASH_BITS;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(HASH_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        rem_reg   <= rem_next;
        sh_reg    <= sh_next;
        step_reg  <= step_next;
        rd_ok_reg <= rd_ok_next;
    end

endmodule

// ===== hw/rtl/chs_back.sv =====
`timescale 1ns / 1ps
// Back end: scans, appends, compacts and reads bucket chains held in RAM,
// and drives the response register. Depends on chs_pkg, chs_out_if, chs_ram.
module chs_back #(
    parameter int BUCKETS     = 11,
    parameter int CHAIN_DEPTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic [chs_pkg::CMD_W + chs_pkg::KEY_W + $clog2(BUCKETS)
                  + $clog2(BUCKETS * CHAIN_DEPTH) : 0] pop_data,
    input  logic      empty,
    output logic      pop,
    output logic      clearing,
    chs_out_if.source response
);

    import chs_pkg::*;

    localparam int BW  = $clog2(BUCKETS);
    localparam int KAW = $clog2(BUCKETS * CHAIN_DEPTH);
    localparam int CW  = $clog2(CHAIN_DEPTH + 1);

    typedef struct packed {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [BW-1:0]    bidx;
        logic [KAW-1:0]   base;
        logic             rd_ok;
    } op_t;

    typedef enum logic [7:0] {
        B_CLEAR  = 8'b00000001,
        B_IDLE   = 8'b00000010,
        B_COUNT  = 8'b00000100,
        B_SCAN   = 8'b00001000,
        B_SHIFT  = 8'b00010000,
        B_RDREQ  = 8'b00100000,
        B_RDOUT  = 8'b01000000,
        B_RESULT = 8'b10000000
    } bstate_t;

    bstate_t          state_reg, state_next;
    op_t              op_reg, op_next, head;
    logic [CW-1:0]    n_reg, n_next;
    logic [CW-1:0]    iss_idx_reg, iss_idx_next;
    logic [CW-1:0]    chk_idx_reg, chk_idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [BW-1:0]    clr_idx_reg, clr_idx_next;
    status_t          res_status_reg, res_status_next;

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [KEY_W-1:0] out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next;
    logic             out_free;

    // RAM ports
    logic             cnt_we, cnt_re;
    logic [BW-1:0]    cnt_waddr, cnt_raddr;
    logic [CW-1:0]    cnt_wdata, cnt_rdata;
    logic             key_we, key_re;
    logic [KAW-1:0]   key_waddr, key_raddr;
    logic [KEY_W-1:0] key_wdata, key_rdata;

    logic             hit, issue;
    logic [CW-1:0]    eff_n;

    chs_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    chs_ram #(.WIDTH(KEY_W), .DEPTH(BUCKETS * CHAIN_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    assign head     = pop_data;
    assign clearing = (state_reg == B_CLEAR);
    assign out_free = !out_valid_reg || response.ready;
    assign hit      = chk_vld_reg && (key_rdata == op_reg.key);
    assign eff_n    = op_reg.rd_ok ? cnt_rdata : '0;

    assign response.valid  = out_valid_reg;
    assign response.status = out_status_reg;
    assign response.value  = out_value_reg;
    assign response.last   = out_last_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        n_next          = n_reg;
        iss_idx_next    = iss_idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        clr_idx_next    = clr_idx_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        pop       = 1'b0;
        issue     = 1'b0;
        cnt_we    = 1'b0;
        cnt_waddr = op_reg.bidx;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = head.bidx;
        key_we    = 1'b0;
        key_waddr = op_reg.base + KAW'(n_reg);
        key_wdata = op_reg.key;
        key_re    = 1'b0;
        key_raddr = op_reg.base + KAW'(iss_idx_reg);

        if (response.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_CLEAR:
            begin
                // zero one bucket count per cycle after reset
                cnt_we       = 1'b1;
                cnt_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + BW'(1);
                if (clr_idx_reg == BW'(BUCKETS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cnt_re     = 1'b1;
                    op_next    = head;
                    state_next = B_COUNT;
                end
            end
            B_COUNT:
            begin
                n_next       = eff_n;
                iss_idx_next = '0;
                chk_vld_next = 1'b0;
                if (op_reg.cmd == CMD_READ)
                begin
                    if (eff_n == '0)
                    begin
                        res_status_next = ST_EMPTY;
                        state_next      = B_RESULT;
                    end
                    else
                    begin
                        state_next = B_RDREQ;
                    end
                end
                else
                begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN:
            begin
                // issue one slot read per cycle, compare the one before
                issue = (iss_idx_reg != n_reg) && !hit;
                if (issue)
                begin
                    key_re       = 1'b1;
                    iss_idx_next = iss_idx_reg + CW'(1);
                end
                chk_vld_next = issue;
                chk_idx_next = iss_idx_reg;
                if (hit)
                begin
                    if (op_reg.cmd == CMD_INSERT)
                    begin
                        res_status_next = ST_DUPLICATE;
                        state_next      = B_RESULT;
                    end
                    else
                    begin
                        iss_idx_next = chk_idx_reg + CW'(1);
                        chk_vld_next = 1'b0;
                        state_next   = B_SHIFT;
                    end
                end
                else if ((iss_idx_reg == n_reg) && !chk_vld_reg)
                begin
                    state_next = B_RESULT;
                    if (op_reg.cmd == CMD_REMOVE)
                    begin
                        res_status_next = ST_ABSENT;
                    end
                    else if (n_reg == CW'(CHAIN_DEPTH))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        // append at the chain tail
                        key_we          = 1'b1;
                        cnt_we          = 1'b1;
                        cnt_wdata       = n_reg + CW'(1);
                        res_status_next = ST_INSERTED;
                    end
                end
            end
            B_SHIFT:
            begin
                // move later keys down one slot: read i+1, write i next cycle
                if (chk_vld_reg)
                begin
                    key_we    = 1'b1;
                    key_waddr = op_reg.base + KAW'(chk_idx_reg);
                    key_wdata = key_rdata;
                end
                issue = (iss_idx_reg < n_reg);
                if (issue)
                begin
                    key_re       = 1'b1;
                    iss_idx_next = iss_idx_reg + CW'(1);
                    chk_idx_next = iss_idx_reg - CW'(1);
                end
                chk_vld_next = issue;
                if (!issue && !chk_vld_reg)
                begin
                    cnt_we          = 1'b1;
                    cnt_wdata       = n_reg - CW'(1);
                    res_status_next = ST_REMOVED;
                    state_next      = B_RESULT;
                end
            end
            B_RDREQ:
            begin
                key_re     = 1'b1;
                state_next = B_RDOUT;
            end
            B_RDOUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_ENTRY;
                    out_value_next  = key_rdata;
                    out_last_next   = ((iss_idx_reg + CW'(1)) == n_reg);
                    iss_idx_next    = iss_idx_reg + CW'(1);
                    if ((iss_idx_reg + CW'(1)) == n_reg)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        state_next = B_RDREQ;
                    end
                end
            end
            B_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = op_reg.key;
                    out_last_next   = 1'b1;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_idx_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        n_reg          <= n_next;
        iss_idx_reg    <= iss_idx_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ===== hw/rtl/chained_hash_set_unit.sv =====
`timescale 1ns / 1ps
// Chained hash set top level: front (hash), two-entry queue, back (chains).
// Depends on chs_pkg, chs_if, chs_fifo, chs_front, chs_back, chs_ram.
//
// A set of 31-bit keys in BUCKETS chains of up to CHAIN_DEPTH keys, bucket =
// key mod BUCKETS. Insert and remove requests give one response; a read gives
// one entry response per stored key (last marks the final one) or one empty
// response. After reset the block clears the bucket counts and takes no
// request until that pass is done. The front computes key mod BUCKETS four
// key bits a cycle; an insert or remove passes accept, hash and hand-off in
// the front. This overlaps the back end's work on the previous request through
// a two-entry queue. The back end fetches the bucket count, then for insert
// and remove scans the chain through the single key RAM read port (a match
// stops the scan early), compacts the chain after a removal and posts the
// response. A read fetches and posts the stored keys one after another once
// the count is in.
module chained_hash_set_unit #(
    parameter int BUCKETS     = 11,
    parameter int CHAIN_DEPTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    chs_in_if.sink    request,
    chs_out_if.source response
);

    import chs_pkg::*;

    localparam int OP_W = CMD_W + KEY_W + $clog2(BUCKETS)
                          + $clog2(BUCKETS * CHAIN_DEPTH) + 1;

    logic            push, full, pop, empty, clearing;
    logic [OP_W-1:0] push_data, pop_data;

    chs_front #(.BUCKETS(BUCKETS), .CHAIN_DEPTH(CHAIN_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .clearing  (clearing),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    chs_fifo #(.WIDTH(OP_W), .DEPTH(2)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_data),
        .full  (full),
        .pop   (pop),
        .rdata (pop_data),
        .empty (empty)
    );

    chs_back #(.BUCKETS(BUCKETS), .CHAIN_DEPTH(CHAIN_DEPTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_data),
        .empty    (empty),
        .pop      (pop),
        .clearing (clearing),
        .response (response)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for chained_hash_set_unit: clocked driver and monitor.
// Depends on chs_pkg, chs_if and the chained_hash_set_unit RTL.
module tb;

    import chs_pkg::*;

    localparam int BUCKETS      = 11;
    localparam int CHAIN_DEPTH  = 8;
    localparam int RANDOM_ITEMS = 74;
    localparam int TAIL_ITEMS   = 20;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int POOL_SIZE    = 24;

    localparam logic [KEY_W-1:0] KEY_MAX    = {KEY_W{1'b1}};
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
        logic [SEL_W-1:0] bucket;
    } set_request_t;

    typedef struct packed {
        status_t          status;
        logic [KEY_W-1:0] value;
        logic             last;
    } set_response_t;

    logic clk;
    logic rst_n;

    chs_in_if  req_bus ();
    chs_out_if rsp_bus ();

    chained_hash_set_unit #(
        .BUCKETS     (BUCKETS),
        .CHAIN_DEPTH (CHAIN_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_bus),
        .response (rsp_bus)
    );

    // shadow copy of the set
    logic [KEY_W-1:0] chain_keys [BUCKETS][CHAIN_DEPTH];
    int               chain_fill [BUCKETS] = '{default: 0};

    set_request_t  pending_requests [$];
    set_response_t predicted_responses [$];
    set_response_t captured_responses [$];

    set_request_t  active_req;
    set_response_t got_resp;
    set_response_t want_resp;

    int  status_hits [7] = '{default: 0};
    int  errors = 0;
    int  requests_accepted = 0;
    int  responses_checked = 0;
    int  total_requests;
    int  cycle_count = 0;
    int  gap_left;
    int  stall_left;
    logic quiet;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // queue one predicted response
    function automatic void add_expected(input status_t st, input logic [KEY_W-1:0] val,
                                         input logic lst);
        set_response_t r;
        r.status = st;
        r.value  = val;
        r.last   = lst;
        predicted_responses.push_back(r);
        status_hits[int'(st)]++;
    endfunction

    // apply one accepted request to the shadow set and predict its responses
    function automatic void predict_request(input set_request_t r);
        int b;
        int n;
        int pos;
        int sel;
        b   = int'(r.key % BUCKETS);
        n   = chain_fill[b];
        pos = n;
        for (int i = n - 1; i >= 0; i--)
            if (chain_keys[b][i] == r.key)
                pos = i;
        case (r.command)
            CMD_INSERT:
            begin
                if (pos < n)
                    add_expected(ST_DUPLICATE, r.key, 1'b1);
                else if (n >= CHAIN_DEPTH)
                    add_expected(ST_FULL, r.key, 1'b1);
                else
                begin
                    chain_keys[b][n] = r.key;
                    chain_fill[b]    = n + 1;
                    add_expected(ST_INSERTED, r.key, 1'b1);
                end
            end
            CMD_REMOVE:
            begin
                if (pos >= n)
                    add_expected(ST_ABSENT, r.key, 1'b1);
                else
                begin
                    // close the gap, keeping insertion order
                    for (int i = pos; i < n - 1; i++)
                        chain_keys[b][i] = chain_keys[b][i + 1];
                    chain_fill[b] = n - 1;
                    add_expected(ST_REMOVED, r.key, 1'b1);
                end
            end
            CMD_READ:
            begin
                sel = int'(r.bucket);
                n   = (sel < BUCKETS) ? chain_fill[sel] : 0;
                if (n == 0)
                    add_expected(ST_EMPTY, r.key, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                        add_expected(ST_ENTRY, chain_keys[sel][i], i == n - 1);
            end
            default:
                ; // unused command code: no response
        endcase
    endfunction

    // random key that hashes to bucket b
    function automatic logic [KEY_W-1:0] key_in_bucket(input int b);
        logic [31:0] k;
        k = BUCKETS * $urandom_range(0, 195225785) + b;
        return k[KEY_W-1:0];
    endfunction

    function automatic void queue_request(input logic [CMD_W-1:0] cmd,
                                          input logic [KEY_W-1:0] key,
                                          input logic [SEL_W-1:0] bkt);
        set_request_t r;
        r.command = cmd;
        r.key     = key;
        r.bucket  = bkt;
        pending_requests.push_back(r);
    endfunction

    function automatic logic [KEY_W-1:0] any_key();
        logic [31:0] k;
        k = $urandom;
        return k[KEY_W-1:0];
    endfunction

    // request driver: random gaps after accepted requests, none near the end
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid   <= 1'b0;
            req_bus.command <= CMD_INSERT;
            req_bus.key     <= '0;
            req_bus.bucket  <= '0;
            quiet           <= 1'b0;
            gap_left         = 0;
        end
        else
        begin
            quiet <= (pending_requests.size() <= TAIL_ITEMS);
            if (req_bus.valid && req_bus.ready)
            begin
                predict_request(active_req);
                requests_accepted++;
                if (!quiet && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 14);
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    active_req       = pending_requests.pop_front();
                    req_bus.valid   <= 1'b1;
                    req_bus.command <= active_req.command;
                    req_bus.key     <= active_req.key;
                    req_bus.bucket  <= active_req.bucket;
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // response monitor: capture accepted responses, stall in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left     = 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
                captured_responses.push_back('{status_t'(rsp_bus.status), rsp_bus.value,
                                               rsp_bus.last});
            if (stall_left > 0)
                stall_left--;
            else if (!quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 14);
            rsp_bus.ready <= (stall_left == 0);
        end
    end

    // compare captured responses with predictions on the falling clock edge
    always @(negedge clk)
    begin
        while (captured_responses.size() > 0)
        begin
            got_resp = captured_responses.pop_front();
            if (predicted_responses.size() == 0)
            begin
                errors++;
                $display("%0t: response with none expected: status=%0d value=%h last=%0b",
                         $time, got_resp.status, got_resp.value, got_resp.last);
            end
            else
            begin
                want_resp = predicted_responses.pop_front();
                responses_checked++;
                if (got_resp.status !== want_resp.status)
                begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want_resp.status, got_resp.status);
                end
                if (got_resp.value !== want_resp.value)
                begin
                    errors++;
                    $display("%0t: value mismatch: expected %h, got %h",
                             $time, want_resp.value, got_resp.value);
                end
                if (got_resp.last !== want_resp.last)
                begin
                    errors++;
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, want_resp.last, got_resp.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d responses outstanding",
                     $time, predicted_responses.size());
            $display("** chained_hash_set_unit: FAILED **");
            $finish;
        end
    end

    // stimulus and end of test
    initial
    begin
        logic [KEY_W-1:0] fill_keys [CHAIN_DEPTH];
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [KEY_W-1:0] key;
        logic [SEL_W-1:0] bkt;
        int hot;
        int pick;

        rst_n = 1'b0;

        // directed: empty read, key extremes, duplicate
        queue_request(CMD_READ, any_key(), 4'd0);
        queue_request(CMD_INSERT, '0, 4'($urandom));
        queue_request(CMD_INSERT, KEY_MAX, 4'($urandom));
        queue_request(CMD_INSERT, '0, 4'($urandom));

        // directed: fill bucket 3, overflow it, duplicate into the full bucket
        for (int i = 0; i < CHAIN_DEPTH; i++)
        begin
            fill_keys[i] = key_in_bucket(3);
            queue_request(CMD_INSERT, fill_keys[i], 4'($urandom));
        end
        queue_request(CMD_INSERT, key_in_bucket(3), 4'($urandom));
        queue_request(CMD_INSERT, fill_keys[5], 4'($urandom));
        queue_request(CMD_READ, any_key(), 4'd3);

        // directed: removes from the middle, front and back, and a missing key
        queue_request(CMD_REMOVE, fill_keys[2], 4'($urandom));
        queue_request(CMD_REMOVE, key_in_bucket(3), 4'($urandom));
        queue_request(CMD_REMOVE, fill_keys[0], 4'($urandom));
        queue_request(CMD_REMOVE, fill_keys[CHAIN_DEPTH - 1], 4'($urandom));
        queue_request(CMD_READ, any_key(), 4'd3);

        // directed: out-of-range buckets, unused command, remaining buckets
        queue_request(CMD_READ, any_key(), 4'd15);
        queue_request(CMD_READ, any_key(), 4'd11);
        queue_request(CMD_UNUSED, any_key(), 4'($urandom));
        queue_request(CMD_READ, any_key(), 4'd1);
        queue_request(CMD_REMOVE, KEY_MAX, 4'($urandom));
        queue_request(CMD_READ, any_key(), 4'd0);

        // random: a key pool with half its keys in one hot bucket so chains fill up
        hot = $urandom_range(0, BUCKETS - 1);
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i < POOL_SIZE / 2) ? key_in_bucket(hot)
                                              : key_in_bucket($urandom_range(0, BUCKETS - 1));
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            key  = ($urandom_range(0, 9) == 0) ? any_key()
                                               : key_pool[$urandom_range(0, POOL_SIZE - 1)];
            bkt  = 4'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 50)
                queue_request(CMD_INSERT, key, bkt);
            else if (pick < 78)
                queue_request(CMD_REMOVE, key, bkt);
            else if (pick < 96)
            begin
                if ($urandom_range(0, 2) == 0)
                    bkt = 4'(hot);
                else if ($urandom_range(0, 6) != 0)
                    bkt = 4'($urandom_range(0, BUCKETS - 1));
                queue_request(CMD_READ, key, bkt);
            end
            else
                queue_request(CMD_UNUSED, key, bkt);
        end
        total_requests = pending_requests.size();

        // reset
        repeat (5) @(posedge clk);
        rst_n = 1'b1;

        // wait for every request, then every response, then let the block settle
        while (requests_accepted < total_requests)
            @(posedge clk);
        while (predicted_responses.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        #1;
        if (predicted_responses.size() > 0)
            $display("%0t: %0d expected responses never arrived",
                     $time, predicted_responses.size());

        $display("Ran %0d requests: %0d inserted, %0d duplicate, %0d full, %0d removed, %0d absent",
                 total_requests, status_hits[ST_INSERTED], status_hits[ST_DUPLICATE],
                 status_hits[ST_FULL], status_hits[ST_REMOVED], status_hits[ST_ABSENT]);
        $display("Reads gave %0d entries and %0d empty answers; %0d responses checked",
                 status_hits[ST_ENTRY], status_hits[ST_EMPTY], responses_checked);
        if (errors == 0 && predicted_responses.size() == 0)
            $display("** chained_hash_set_unit: PASSED **");
        else
            $display("** chained_hash_set_unit: FAILED **");
        $finish;
    end

endmodule
